[rtl/wef_pkg.sv]
// ----------------------------------------------------------------------------
// wef_pkg
// Shared types, constants and codes of the weighted ensemble fusion block.
// ----------------------------------------------------------------------------
package wef_pkg;

  localparam int MAX_EXPERTS = 4;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = 2;
  localparam int CNT_W       = 3;
  localparam int WT_W        = 16;
  localparam int IN_W        = 18;
  localparam int VAL_W       = 17;
  localparam int ACC_W       = 36;
  localparam int WACC_W      = 19;
  localparam int DIV_W       = 50;
  localparam int TERM_W      = 33;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [VAL_W-1:0] ONE_FX  = VAL_W'(1 << FRAC_BITS);
  localparam logic [VAL_W-1:0] UNC_MAX = {VAL_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WT0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WT3  = 3'd4;

  localparam logic [1:0] MM_VAR = 2'd0;
  localparam logic [1:0] MM_MAD = 2'd1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_ZERO_W = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] unc;
    logic [WT_W-1:0]  wt;
    logic             avail;
    logic             last;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MEAN_GO, S_MEAN_WT, S_UNC_GO, S_UNC_WT,
    S_SQ, S_ACC, S_DIS_GO, S_DIS_WT, S_RANGE, S_DONE
  } be_state_t;

endpackage

[rtl/wef_front.sv]
// ----------------------------------------------------------------------------
// wef_front
// Configuration registers, input capture and clipping of each prediction.
// ----------------------------------------------------------------------------
module wef_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wef_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wef_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 push_ok,
  input  logic                                 start,
  input  logic [wef_pkg::IDX_W-1:0]            in_expert_index,
  input  logic signed [wef_pkg::IN_W-1:0]      in_pred_mean,
  input  logic signed [wef_pkg::IN_W-1:0]      in_pred_uncertainty,
  input  logic                                 in_available,
  input  logic                                 in_last_item,
  output logic                                 push,
  output wef_pkg::item_t                       item,
  output logic [1:0]                           metric_mode
);

  logic [1:0]                 mode_r;
  logic [wef_pkg::WT_W-1:0]   wt_r [wef_pkg::MAX_EXPERTS];

  assign cfg_ready   = 1'b1;
  assign metric_mode = mode_r;
  assign push        = start && push_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= wef_pkg::MM_VAR;
      for (int i = 0; i < wef_pkg::MAX_EXPERTS; i++) wt_r[i] <= wef_pkg::WT_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == wef_pkg::CFG_MODE) begin
        mode_r <= cfg_data[1:0];
      end else if (cfg_index >= wef_pkg::CFG_WT0 && cfg_index <= wef_pkg::CFG_WT3) begin
        wt_r[wef_pkg::IDX_W'(cfg_index - wef_pkg::CFG_WT0)] <= cfg_data;
      end
    end
  end

  always_comb begin
    if (in_pred_mean < 0) begin
      item.mean = '0;
    end else if (in_pred_mean > $signed({1'b0, wef_pkg::ONE_FX})) begin
      item.mean = wef_pkg::ONE_FX;
    end else begin
      item.mean = in_pred_mean[wef_pkg::VAL_W-1:0];
    end
    item.unc   = in_pred_uncertainty[wef_pkg::IN_W-1] ? '0
               : in_pred_uncertainty[wef_pkg::VAL_W-1:0];
    item.wt    = wt_r[in_expert_index];
    item.avail = in_available;
    item.last  = in_last_item;
  end

endmodule

[rtl/wef_queue.sv]
// ----------------------------------------------------------------------------
// wef_queue
// Short queue of clipped predictions between front and back.
// ----------------------------------------------------------------------------
module wef_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wef_pkg::item_t push_item,
  input  logic           pop,
  output wef_pkg::item_t pop_item,
  output logic           empty,
  output logic           full
);

  wef_pkg::item_t                mem_r [wef_pkg::QDEPTH];
  logic [wef_pkg::QPTR_W-1:0]    wp_r, rp_r;
  logic [wef_pkg::QPTR_W:0]      cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (wef_pkg::QPTR_W+1)'(wef_pkg::QDEPTH));
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[rtl/wef_div.sv]
// ----------------------------------------------------------------------------
// wef_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wef_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wef_pkg::DIV_W-1:0]     dividend,
  input  logic [wef_pkg::WACC_W-1:0]    divisor,
  output logic                          done,
  output logic [wef_pkg::DIV_W-1:0]     quotient
);

  localparam int CW = $clog2(wef_pkg::DIV_W);

  logic [wef_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [wef_pkg::WACC_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [CW-1:0]              cnt_r;
  logic                       run_r, done_r;
  logic [wef_pkg::WACC_W:0]   shifted, diff;
  logic                       ge;

  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    shifted = {rem_r, quo_r[wef_pkg::DIV_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
    rem_nxt = ge ? diff[wef_pkg::WACC_W-1:0] : shifted[wef_pkg::WACC_W-1:0];
    quo_nxt = {quo_r[wef_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(wef_pkg::DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/wef_back.sv]
// ----------------------------------------------------------------------------
// wef_back
// Accumulation, final divides, disagreement pass and result register.
// ----------------------------------------------------------------------------
module wef_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  wef_pkg::item_t                q_item,
  output logic                          pop,
  input  logic [1:0]                    metric_mode,
  output logic                          out_valid,
  output logic [wef_pkg::VAL_W-1:0]     out_fused_value,
  output logic [wef_pkg::VAL_W-1:0]     out_fused_uncertainty,
  output logic [wef_pkg::VAL_W-1:0]     out_disagreement,
  output logic [wef_pkg::CNT_W-1:0]     out_active_count,
  output logic [1:0]                    out_status
);

  localparam int ME = wef_pkg::MAX_EXPERTS;
  localparam int XW = $clog2(ME);

  wef_pkg::be_state_t st_r, st_nxt;

  logic [wef_pkg::VAL_W-1:0]  means_r [ME];
  logic [wef_pkg::WT_W-1:0]   wts_r   [ME];
  logic [wef_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [wef_pkg::ACC_W-1:0]  macc_r, macc_nxt, uacc_r, uacc_nxt;
  logic [wef_pkg::WACC_W-1:0] wacc_r, wacc_nxt;
  logic [wef_pkg::DIV_W-1:0]  dacc_r, dacc_nxt;
  logic [wef_pkg::TERM_W-1:0] term_r, term_nxt;
  logic [wef_pkg::VAL_W-1:0]  mean_r, mean_nxt, unc_r, unc_nxt, dis_r, dis_nxt;
  logic [XW-1:0]              idx_r, idx_nxt;
  logic                       store, wr_en;

  logic                       ov_r, ov_nxt;
  logic [wef_pkg::VAL_W-1:0]  ofv_r, ofv_nxt, ofu_r, ofu_nxt, odis_r, odis_nxt;
  logic [wef_pkg::CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic [1:0]                 ost_r, ost_nxt;

  logic                       div_start, div_done;
  logic [wef_pkg::DIV_W-1:0]  div_dnd, div_q, vq;
  logic [wef_pkg::TERM_W-1:0] pm, pu;
  logic [wef_pkg::VAL_W-1:0]  dabs, lo, hi;
  logic [2*wef_pkg::VAL_W-1:0] dsq;
  logic [wef_pkg::TERM_W+wef_pkg::WT_W-1:0] pw;

  wef_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dnd),
    .divisor  (wacc_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid             = ov_r;
  assign out_fused_value       = ofv_r;
  assign out_fused_uncertainty = ofu_r;
  assign out_disagreement      = odis_r;
  assign out_active_count      = ocnt_r;
  assign out_status            = ost_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      means_r[cnt_r[XW-1:0]] <= q_item.mean;
      wts_r[cnt_r[XW-1:0]]   <= q_item.wt;
    end
  end

  always_comb begin
    pm   = q_item.wt * q_item.mean;
    pu   = q_item.wt * q_item.unc;
    dabs = (means_r[idx_r] >= mean_r) ? means_r[idx_r] - mean_r : mean_r - means_r[idx_r];
    dsq  = dabs * dabs;
    pw   = wts_r[idx_r] * term_r;
    vq   = div_q >> wef_pkg::FRAC_BITS;
    lo   = means_r[0];
    hi   = means_r[0];
    for (int i = 1; i < ME; i++) begin
      if (wef_pkg::CNT_W'(i) < cnt_r) begin
        if (means_r[i] < lo) lo = means_r[i];
        if (means_r[i] > hi) hi = means_r[i];
      end
    end
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    macc_nxt  = macc_r;
    uacc_nxt  = uacc_r;
    wacc_nxt  = wacc_r;
    dacc_nxt  = dacc_r;
    term_nxt  = term_r;
    mean_nxt  = mean_r;
    unc_nxt   = unc_r;
    dis_nxt   = dis_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    ofv_nxt   = ofv_r;
    ofu_nxt   = ofu_r;
    odis_nxt  = odis_r;
    ocnt_nxt  = ocnt_r;
    ost_nxt   = ost_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    store     = 1'b0;
    div_start = 1'b0;
    div_dnd   = '0;
    case (st_r)
      wef_pkg::S_IDLE: begin
        if (!q_empty) begin
          pop   = 1'b1;
          store = q_item.avail && (cnt_r < wef_pkg::CNT_W'(ME));
          if (store) begin
            wr_en    = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            macc_nxt = macc_r + wef_pkg::ACC_W'(pm);
            uacc_nxt = uacc_r + wef_pkg::ACC_W'(pu);
            wacc_nxt = wacc_r + wef_pkg::WACC_W'(q_item.wt);
          end
          if (q_item.last) st_nxt = wef_pkg::S_CHECK;
        end
      end
      wef_pkg::S_CHECK: begin
        if (cnt_r == '0 || wacc_r == '0) begin
          ov_nxt   = 1'b1;
          ofv_nxt  = '0;
          ofu_nxt  = '0;
          odis_nxt = '0;
          ocnt_nxt = cnt_r;
          ost_nxt  = wef_pkg::ST_ZERO_W;
          if (cnt_r == '0) ost_nxt = wef_pkg::ST_NONE;
          cnt_nxt  = '0;
          macc_nxt = '0;
          uacc_nxt = '0;
          wacc_nxt = '0;
          st_nxt   = wef_pkg::S_IDLE;
        end else begin
          st_nxt = wef_pkg::S_MEAN_GO;
        end
      end
      wef_pkg::S_MEAN_GO: begin
        div_start = 1'b1;
        div_dnd   = wef_pkg::DIV_W'(macc_r);
        st_nxt    = wef_pkg::S_MEAN_WT;
      end
      wef_pkg::S_MEAN_WT: begin
        if (div_done) begin
          mean_nxt = (div_q > wef_pkg::DIV_W'(wef_pkg::ONE_FX)) ? wef_pkg::ONE_FX
                   : div_q[wef_pkg::VAL_W-1:0];
          st_nxt   = wef_pkg::S_UNC_GO;
        end
      end
      wef_pkg::S_UNC_GO: begin
        div_start = 1'b1;
        div_dnd   = wef_pkg::DIV_W'(uacc_r);
        st_nxt    = wef_pkg::S_UNC_WT;
      end
      wef_pkg::S_UNC_WT: begin
        if (div_done) begin
          unc_nxt  = (div_q > wef_pkg::DIV_W'(wef_pkg::UNC_MAX)) ? wef_pkg::UNC_MAX
                   : div_q[wef_pkg::VAL_W-1:0];
          idx_nxt  = '0;
          dacc_nxt = '0;
          if (metric_mode == wef_pkg::MM_VAR || metric_mode == wef_pkg::MM_MAD) begin
            st_nxt = wef_pkg::S_SQ;
          end else begin
            st_nxt = wef_pkg::S_RANGE;
          end
        end
      end
      wef_pkg::S_SQ: begin
        term_nxt = (metric_mode == wef_pkg::MM_VAR) ? dsq[wef_pkg::TERM_W-1:0]
                 : wef_pkg::TERM_W'(dabs);
        st_nxt   = wef_pkg::S_ACC;
      end
      wef_pkg::S_ACC: begin
        dacc_nxt = dacc_r + wef_pkg::DIV_W'(pw);
        idx_nxt  = idx_r + 1'b1;
        if (wef_pkg::CNT_W'(idx_r) == cnt_r - 1'b1) begin
          st_nxt = wef_pkg::S_DIS_GO;
        end else begin
          st_nxt = wef_pkg::S_SQ;
        end
      end
      wef_pkg::S_DIS_GO: begin
        div_start = 1'b1;
        div_dnd   = dacc_r;
        st_nxt    = wef_pkg::S_DIS_WT;
      end
      wef_pkg::S_DIS_WT: begin
        if (div_done) begin
          if (metric_mode == wef_pkg::MM_VAR) begin
            dis_nxt = (vq > wef_pkg::DIV_W'(wef_pkg::ONE_FX)) ? wef_pkg::ONE_FX
                    : vq[wef_pkg::VAL_W-1:0];
          end else begin
            dis_nxt = (div_q > wef_pkg::DIV_W'(wef_pkg::ONE_FX)) ? wef_pkg::ONE_FX
                    : div_q[wef_pkg::VAL_W-1:0];
          end
          st_nxt = wef_pkg::S_DONE;
        end
      end
      wef_pkg::S_RANGE: begin
        dis_nxt = (hi - lo > wef_pkg::ONE_FX) ? wef_pkg::ONE_FX : hi - lo;
        st_nxt  = wef_pkg::S_DONE;
      end
      wef_pkg::S_DONE: begin
        ov_nxt   = 1'b1;
        ofv_nxt  = mean_r;
        ofu_nxt  = unc_r;
        odis_nxt = dis_r;
        ocnt_nxt = cnt_r;
        ost_nxt  = wef_pkg::ST_OK;
        cnt_nxt  = '0;
        macc_nxt = '0;
        uacc_nxt = '0;
        wacc_nxt = '0;
        st_nxt   = wef_pkg::S_IDLE;
      end
      default: begin
        st_nxt = wef_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= wef_pkg::S_IDLE;
      cnt_r  <= '0;
      macc_r <= '0;
      uacc_r <= '0;
      wacc_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      macc_r <= macc_nxt;
      uacc_r <= uacc_nxt;
      wacc_r <= wacc_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dacc_r <= dacc_nxt;
    term_r <= term_nxt;
    mean_r <= mean_nxt;
    unc_r  <= unc_nxt;
    dis_r  <= dis_nxt;
    idx_r  <= idx_nxt;
    ofv_r  <= ofv_nxt;
    ofu_r  <= ofu_nxt;
    odis_r <= odis_nxt;
    ocnt_r <= ocnt_nxt;
    ost_r  <= ost_nxt;
  end

endmodule

[rtl/weighted_ensemble_fusion_top.sv]
// ----------------------------------------------------------------------------
// weighted_ensemble_fusion_top
// Fuses up to four expert predictions into mean, uncertainty and spread.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy rises only
// while the two-entry queue in front of the arithmetic is full. An item that
// does not close a set is taken by the back end in its idle state. A set-closing
// item holds the back end through the check state, the mean and uncertainty
// divides, then either a deviation pass and a spread divide for variance or
// absolute deviation, or the range step for range, and the result register.
// Each divide runs on the shared bit-serial divider (launch, 50-bit quotient,
// completion); the deviation pass takes a square and an accumulate step per
// stored prediction. An empty set or a zero weight sum is reported straight
// from the check state. The result is shown for one cycle on out_valid, in the
// cycle after the back end finishes, and cannot be stalled.
module weighted_ensemble_fusion_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wef_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wef_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [wef_pkg::IDX_W-1:0]            in_expert_index,
  input  logic signed [wef_pkg::IN_W-1:0]      in_pred_mean,
  input  logic signed [wef_pkg::IN_W-1:0]      in_pred_uncertainty,
  input  logic                                 in_available,
  input  logic                                 in_last_item,
  output logic                                 out_valid,
  output logic [wef_pkg::VAL_W-1:0]            out_fused_value,
  output logic [wef_pkg::VAL_W-1:0]            out_fused_uncertainty,
  output logic [wef_pkg::VAL_W-1:0]            out_disagreement,
  output logic [wef_pkg::CNT_W-1:0]            out_active_count,
  output logic [1:0]                           out_status
);

  wef_pkg::item_t push_item, pop_item;
  logic           push, pop, q_empty, q_full;
  logic [1:0]     metric_mode;

  assign busy = q_full;

  wef_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .push_ok             (!q_full),
    .start               (start),
    .in_expert_index     (in_expert_index),
    .in_pred_mean        (in_pred_mean),
    .in_pred_uncertainty (in_pred_uncertainty),
    .in_available        (in_available),
    .in_last_item        (in_last_item),
    .push                (push),
    .item                (push_item),
    .metric_mode         (metric_mode)
  );

  wef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  wef_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_item                (pop_item),
    .pop                   (pop),
    .metric_mode           (metric_mode),
    .out_valid             (out_valid),
    .out_fused_value       (out_fused_value),
    .out_fused_uncertainty (out_fused_uncertainty),
    .out_disagreement      (out_disagreement),
    .out_active_count      (out_active_count),
    .out_status            (out_status)
  );

endmodule

[rtl/wef_checker.sv]
// ----------------------------------------------------------------------------
// wef_checker
// Port-level checks of the fusion block's results.
// ----------------------------------------------------------------------------
module wef_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 out_valid,
  input  logic [wef_pkg::VAL_W-1:0]            out_fused_value,
  input  logic [wef_pkg::VAL_W-1:0]            out_fused_uncertainty,
  input  logic [wef_pkg::VAL_W-1:0]            out_disagreement,
  input  logic [wef_pkg::CNT_W-1:0]            out_active_count,
  input  logic [1:0]                           out_status
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fused_value <= wef_pkg::ONE_FX && out_disagreement <= wef_pkg::ONE_FX)
    else $error("fused value or disagreement above one");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wef_pkg::ST_NONE |->
      out_active_count == '0 && out_fused_value == '0 && out_fused_uncertainty == '0)
    else $error("empty set reported nonzero fields");

  a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wef_pkg::ST_ZERO_W |->
      out_active_count != '0 && out_fused_value == '0 && out_disagreement == '0)
    else $error("zero weight result malformed");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_active_count <= wef_pkg::CNT_W'(wef_pkg::MAX_EXPERTS)
      && out_status != 2'd3)
    else $error("count or status out of range");

endmodule

bind weighted_ensemble_fusion_top wef_checker u_wef_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives prediction sets into the fusion block under several weight and
// metric settings, predicts each fused result and compares it field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] MODE_RANGE = 2'd2;
  localparam logic [1:0] MODE_ALT   = 2'd3;
  localparam int SET_DRAIN  = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [wef_pkg::VAL_W-1:0] value;
    logic [wef_pkg::VAL_W-1:0] unc;
    logic [wef_pkg::VAL_W-1:0] dis;
    logic [wef_pkg::CNT_W-1:0] cnt;
    logic [1:0]                status;
  } fusion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wef_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wef_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [wef_pkg::IDX_W-1:0] in_expert_index = '0;
  logic signed [wef_pkg::IN_W-1:0] in_pred_mean = '0;
  logic signed [wef_pkg::IN_W-1:0] in_pred_uncertainty = '0;
  logic in_available = 1'b0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic [wef_pkg::VAL_W-1:0] out_fused_value, out_fused_uncertainty, out_disagreement;
  logic [wef_pkg::CNT_W-1:0] out_active_count;
  logic [1:0] out_status;

  always #2 clk = ~clk;

  weighted_ensemble_fusion_top u_top (.*);

  logic [1:0] mode_q;
  logic [15:0] wt_q [4];
  logic [16:0] set_means [wef_pkg::MAX_EXPERTS];
  logic [15:0] set_wts [wef_pkg::MAX_EXPERTS];
  int unsigned set_cnt;
  logic [35:0] macc, uacc;
  logic [18:0] wacc;
  fusion_t fused_q [$];
  int errors = 0;
  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [16:0] got, input logic [16:0] exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    fusion_t e;
    if (rst_n && out_valid) begin
      if (fused_q.size() == 0) begin
        report("unexpected result", out_fused_value, 17'd0);
      end else begin
        e = fused_q.pop_front();
        if (out_fused_value !== e.value) report("value", out_fused_value, e.value);
        if (out_fused_uncertainty !== e.unc) report("unc", out_fused_uncertainty, e.unc);
        if (out_disagreement !== e.dis) report("dis", out_disagreement, e.dis);
        if (out_active_count !== e.cnt)
          report("count", 17'(out_active_count), 17'(e.cnt));
        if (out_status !== e.status) report("status", 17'(out_status), 17'(e.status));
      end
    end
  end

  function automatic void clear_set();
    set_cnt = 0; macc = '0; uacc = '0; wacc = '0;
  endfunction

  function automatic void predict_fusion(input logic [1:0] idx, input logic signed [17:0] m_raw,
                                         input logic signed [17:0] u_raw, input logic av,
                                         input logic lst);
    fusion_t r;
    logic [63:0] m, u, w, mean, acc, d, unc, dis, lo, hi;
    r = '0;
    if (av && set_cnt < wef_pkg::MAX_EXPERTS) begin
      m = m_raw < 0 ? 64'd0 : (m_raw > 65536 ? 64'd65536 : 64'(m_raw));
      u = u_raw < 0 ? 64'd0 : 64'(u_raw);
      w = 64'(wt_q[idx]);
      set_means[set_cnt] = m[16:0];
      set_wts[set_cnt] = w[15:0];
      set_cnt++;
      macc = macc + 36'(w * m);
      uacc = uacc + 36'(w * u);
      wacc = wacc + 19'(w);
    end
    if (!lst) return;
    if (set_cnt == 0) r.status = wef_pkg::ST_NONE;
    else if (wacc == 0) begin
      r.status = wef_pkg::ST_ZERO_W; r.cnt = wef_pkg::CNT_W'(set_cnt);
    end else begin
      r.status = wef_pkg::ST_OK; r.cnt = wef_pkg::CNT_W'(set_cnt);
      mean = 64'(macc) / 64'(wacc);
      unc = 64'(uacc) / 64'(wacc);
      r.unc = unc > 131071 ? 17'h1FFFF : unc[16:0];
      if (mode_q == wef_pkg::MM_VAR || mode_q == wef_pkg::MM_MAD) begin
        acc = 0;
        for (int i = 0; i < set_cnt; i++) begin
          d = set_means[i] >= mean ? set_means[i] - mean : mean - set_means[i];
          acc += (mode_q == wef_pkg::MM_VAR) ? set_wts[i] * d * d : set_wts[i] * d;
        end
        dis = acc / 64'(wacc);
        if (mode_q == wef_pkg::MM_VAR) dis = dis >> wef_pkg::FRAC_BITS;
      end else begin
        lo = 64'(set_means[0]); hi = 64'(set_means[0]);
        for (int i = 1; i < set_cnt; i++) begin
          if (set_means[i] < lo) lo = 64'(set_means[i]);
          if (set_means[i] > hi) hi = 64'(set_means[i]);
        end
        dis = hi - lo;
      end
      r.dis = dis > 65536 ? 17'd65536 : dis[16:0];
      r.value = mean > 65536 ? 17'd65536 : mean[16:0];
    end
    fused_q = {fused_q, r};
    clear_set();
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n != 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input logic [1:0] idx, input logic signed [17:0] m,
                           input logic signed [17:0] u, input logic av, input logic lst,
                           input bit gaps = 1'b1);
    if (gaps) idle_gap();
    start <= 1'b1;
    in_expert_index <= idx; in_pred_mean <= m; in_pred_uncertainty <= u;
    in_available <= av; in_last_item <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_fusion(idx, m, u, av, lst);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == wef_pkg::CFG_MODE) mode_q = val[1:0];
    else wt_q[2'(idx - wef_pkg::CFG_WT0)] = val;
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (fused_q.size() != 0 && n < 100000) begin
      @(posedge clk); n++;
    end
    repeat (SET_DRAIN) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [15:0] w0, input logic [15:0] w1,
                           input logic [15:0] w2, input logic [15:0] w3);
    drain();
    write_reg(wef_pkg::CFG_MODE, 16'(mode));
    write_reg(wef_pkg::CFG_WT0, w0);
    write_reg(wef_pkg::CFG_WT0 + 3'd1, w1);
    write_reg(wef_pkg::CFG_WT0 + 3'd2, w2);
    write_reg(wef_pkg::CFG_WT3, w3);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_set();
    int n;
    logic signed [17:0] m, u;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: m = 18'($urandom);
        1: m = 18'($urandom_range(0, 65536));
        2: m = $urandom_range(0, 1) ? 18'sd65536 : 18'sd0;
        default: m = 18'($urandom_range(60000, 70000));
      endcase
      u = $urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 131071));
      send_item(2'($urandom), m, u, $urandom_range(0, 5) != 0, i == n - 1);
    end
  endtask

  task automatic test_directed();
    configure(wef_pkg::MM_VAR, 16'd1, 16'd1, 16'd1, 16'd1);
    send_item(2'd0, 18'sd0, 18'sd0, 1'b1, 1'b1);
    send_item(2'd1, 18'sh20000, 18'sh20000, 1'b1, 1'b0);
    send_item(2'd2, 18'sd131071, 18'sd131071, 1'b1, 1'b0);
    send_item(2'd3, 18'sd32768, 18'sd100, 1'b1, 1'b1);
    send_item(2'd0, 18'sd5, 18'sd5, 1'b0, 1'b0);
    send_item(2'd1, 18'sd5, 18'sd5, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++)
      send_item(2'(i), 18'(i * 20000), 18'sd7, 1'b1, i == 5, 1'b0);
    send_item(2'd2, 18'sd1000, 18'sd1, 1'b1, 1'b0);
    send_item(2'd2, 18'sd60000, 18'sd1, 1'b1, 1'b1);
    configure(wef_pkg::MM_MAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 4; i++)
      send_item(2'(i), 18'(i * 21845), 18'sd131071, 1'b1, i == 3);
    configure(MODE_RANGE, 16'd0, 16'd0, 16'd5, 16'd0);
    send_item(2'd0, 18'sd100, 18'sd4, 1'b1, 1'b0);
    send_item(2'd1, 18'sd9000, 18'sd4, 1'b1, 1'b1);
    send_item(2'd2, 18'sd100, 18'sd4, 1'b1, 1'b0);
    send_item(2'd0, 18'sd65536, 18'sd4, 1'b1, 1'b1);
  endtask

  task automatic test_random(input logic [1:0] mode, input int sets);
    configure(mode, 16'($urandom), 16'($urandom_range(0, 3)), 16'($urandom), 16'hFFFF);
    for (int s = 0; s < sets; s++) send_random_set();
  endtask

  initial begin
    mode_q = wef_pkg::MM_VAR;
    for (int i = 0; i < 4; i++) wt_q[i] = 16'd1;
    clear_set();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(wef_pkg::MM_VAR, 30);
    test_random(wef_pkg::MM_MAD, 30);
    test_random(MODE_RANGE, 25);
    test_random(MODE_ALT, 25);
    drain();
    if (errors == 0 && fused_q.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

[files.f]
rtl/wef_pkg.sv
rtl/wef_front.sv
rtl/wef_queue.sv
rtl/wef_div.sv
rtl/wef_back.sv
rtl/weighted_ensemble_fusion_top.sv
rtl/wef_checker.sv
tb/sv/tb.sv
